// ===== rtl/msh_pkg.sv =====
// shared types and constants of the multi-series histogram
package msh_pkg;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned SERIES_W   = 3;
  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned BIN_IDX_W  = 16;
  localparam int unsigned VAL_W      = 40;
  localparam int unsigned OUT_W      = 48;
  localparam int unsigned BIN_USED_W = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned BIU_W      = 9;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 2'd0,
    OP_SET = 2'd1,
    OP_GET = 2'd2,
    OP_SUM = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_MIN   = 2'd0,
    REG_BIN_SCALE   = 2'd1,
    REG_BINS_IN_USE = 2'd2,
    REG_NONE        = 2'd3
  } cfg_reg_e;

  localparam logic [SAMPLE_W-1:0] RANGE_MIN_RST   = 32'h0000_0000;
  localparam logic [SAMPLE_W-1:0] BIN_SCALE_RST   = 32'h0001_0000;
  localparam logic [BIU_W-1:0]    BINS_IN_USE_RST = 9'd256;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

// ===== rtl/msh_ram.sv =====
// generic single-write, single-read ram with registered read data
module msh_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/msh_binmap.sv =====
// bin map: registered offset*scale (add) or bin index, then clamp to bins in use
module msh_binmap #(
  parameter int unsigned BINS = 256,
  localparam int unsigned NW  = $clog2(BINS + 1),
  localparam int unsigned BIW = (BINS > 1) ? $clog2(BINS) : 1
) (
  input  logic                                clk_i,
  input  logic                                load_i,
  input  logic                                is_add_i,
  input  logic [msh_pkg::SAMPLE_W-1:0]        sample_i,
  input  logic [msh_pkg::SAMPLE_W-1:0]        range_min_i,
  input  logic [msh_pkg::SAMPLE_W-1:0]        bin_scale_i,
  input  logic [msh_pkg::BIN_IDX_W-1:0]       bin_index_i,
  input  logic [NW-1:0]                       n_i,
  output logic [BIW-1:0]                      bin_o
);
  import msh_pkg::*;

  logic signed [SAMPLE_W:0]   diff;
  logic [2*SAMPLE_W-1:0]      prod;
  logic [SAMPLE_W-1:0]        raw_d, raw_q;
  logic [SAMPLE_W-1:0]        n_ext;
  logic [SAMPLE_W-1:0]        clamped;

  // offset from the range floor, negative offsets land in bin 0
  assign diff = (SAMPLE_W+1)'($signed(sample_i)) - (SAMPLE_W+1)'($signed(range_min_i));
  assign prod = (2*SAMPLE_W)'(diff[SAMPLE_W-1:0]) * (2*SAMPLE_W)'(bin_scale_i);

  always_comb begin
    if (is_add_i) begin
      raw_d = diff[SAMPLE_W] ? '0 : prod[2*SAMPLE_W-1:SAMPLE_W];
    end else begin
      raw_d = SAMPLE_W'(bin_index_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      raw_q <= raw_d;
    end
  end

  assign n_ext   = SAMPLE_W'(n_i);
  assign clamped = (raw_q >= n_ext) ? (n_ext - SAMPLE_W'(1)) : raw_q;
  assign bin_o   = BIW'(clamped);

endmodule

// ===== rtl/msh_alu.sv =====
// shared adder with 40-bit and 48-bit saturation taps
module msh_alu #(
  parameter int unsigned ACCW = 49
) (
  input  logic signed [ACCW-1:0]              a_i,
  input  logic signed [msh_pkg::VAL_W-1:0]    b_i,
  output logic signed [ACCW-1:0]              sum_o,
  output logic signed [msh_pkg::VAL_W-1:0]    sat40_o,
  output logic signed [msh_pkg::OUT_W-1:0]    sat48_o
);
  import msh_pkg::*;

  localparam int unsigned EW = (ACCW > OUT_W + 1) ? ACCW : OUT_W + 1;
  localparam logic signed [EW-1:0] MAX40 = EW'(VAL_MAX);
  localparam logic signed [EW-1:0] MIN40 = EW'(VAL_MIN);
  localparam logic signed [EW-1:0] MAX48 = EW'(OUT_MAX);
  localparam logic signed [EW-1:0] MIN48 = EW'(OUT_MIN);

  logic signed [EW-1:0] a_ext, b_ext, s;

  assign a_ext = EW'(a_i);
  assign b_ext = EW'(b_i);
  assign s     = a_ext + b_ext;
  assign sum_o = ACCW'(s);

  always_comb begin
    if (s > MAX40) begin
      sat40_o = VAL_MAX;
    end else if (s < MIN40) begin
      sat40_o = VAL_MIN;
    end else begin
      sat40_o = s[VAL_W-1:0];
    end
  end

  always_comb begin
    if (s > MAX48) begin
      sat48_o = OUT_MAX;
    end else if (s < MIN48) begin
      sat48_o = OUT_MIN;
    end else begin
      sat48_o = s[OUT_W-1:0];
    end
  end

endmodule

// ===== rtl/multi_series_histogram.sv =====
// top level of the multi-series histogram: sequencer, bin store and result register
//
// Keeps SERIES histograms of BINS bins, each bin a signed Q24.16 value held in one
// ram of SERIES*BINS words. After reset the block runs a clearing pass that writes
// zero to every word, one word a cycle, and takes no word until the pass is done;
// configuration writes are taken at any time (cfg_ready_o is always high). Items are
// handled one at a time by a small sequencer around a shared adder/saturator: add,
// set and get pass from acceptance to a result in the output register through the
// steps S_MAP (sample map with the 32x32 multiply), S_ADDR (clamp and ram read),
// S_EXEC (read-modify-write) and S_FIN (result), and the block takes its next word
// in the cycle that result appears. A sum walks the n active bins of the series
// through the single ram read port, one bin a cycle, n being the active bin count
// (bins_in_use, with zero taken as one and anything above BINS taken as BINS). A sum
// on a series out of range skips the walk. A result still waiting on out_stall_i
// holds the sequencer in its last step and adds those cycles. The output register
// lets the next word be accepted while a result waits on out_stall_i.
module multi_series_histogram #(
  parameter int unsigned BINS   = 256,
  parameter int unsigned SERIES = 4
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // item channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [msh_pkg::OP_W-1:0]              op_i,
  input  logic [msh_pkg::SERIES_W-1:0]          series_i,
  input  logic [msh_pkg::SAMPLE_W-1:0]          sample_i,
  input  logic [msh_pkg::BIN_IDX_W-1:0]         bin_index_i,
  input  logic [msh_pkg::VAL_W-1:0]             amount_i,
  // result channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [msh_pkg::OUT_W-1:0]             value_o,
  output logic [msh_pkg::BIN_USED_W-1:0]        bin_used_o,
  output logic                                  series_error_o,
  // configuration write channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [msh_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [msh_pkg::CFG_DATA_W-1:0]        cfg_data_i
);
  import msh_pkg::*;

  localparam int unsigned DEPTH = SERIES * BINS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW    = $clog2(BINS + 1);
  localparam int unsigned BIW   = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int unsigned CMPW  = (NW > BIU_W) ? NW : BIU_W;
  localparam int unsigned ACCW  = VAL_W + 1 + $clog2(BINS);
  localparam int unsigned XW    = AW + 3;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  // one-hot sequencer states
  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_MAP   = 7'b0000100,
    S_ADDR  = 7'b0001000,
    S_EXEC  = 7'b0010000,
    S_SUM   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [SAMPLE_W-1:0] range_min_q, bin_scale_q;
  logic [BIU_W-1:0]    bins_in_use_q;

  // captured item
  op_e                  op_q;
  logic [SERIES_W-1:0]  series_q;
  logic [SAMPLE_W-1:0]  sample_q;
  logic [BIN_IDX_W-1:0] bin_index_q;
  logic [VAL_W-1:0]     amount_q;
  logic                 err_q;

  // work registers
  logic [BIW-1:0]         bin_q, bin_d;
  logic [OUT_W-1:0]       res_q, res_d;
  logic signed [ACCW-1:0] acc_q, acc_d;
  logic [NW-1:0]          rd_cnt_q, rd_cnt_d;
  logic                   rd_pend_q, rd_pend_d;
  logic [AW-1:0]          clr_cnt_q;

  // output register
  logic                  out_valid_q;
  logic [OUT_W-1:0]      value_q;
  logic [BIN_USED_W-1:0] bin_used_q;
  logic                  out_err_q;

  logic                  in_acc, out_free, load_out;
  logic [NW-1:0]         n_act;
  logic [CMPW-1:0]       biu_ext;
  logic [BIW-1:0]        map_bin;
  logic [XW-1:0]         base;
  logic [BIW-1:0]        walk_idx;
  logic                  issue;

  // ram ports
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [VAL_W-1:0] wdata, rdata;

  // shared adder
  logic signed [ACCW-1:0]  alu_a, alu_sum;
  logic signed [VAL_W-1:0] alu_b, alu_sat40;
  logic signed [OUT_W-1:0] alu_sat48;

  logic [BIW+BIN_USED_W-1:0] bin_used_ext;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  // config writes, any index past the list is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_min_q   <= RANGE_MIN_RST;
      bin_scale_q   <= BIN_SCALE_RST;
      bins_in_use_q <= BINS_IN_USE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_RANGE_MIN:   range_min_q   <= cfg_data_i;
        REG_BIN_SCALE:   bin_scale_q   <= cfg_data_i;
        REG_BINS_IN_USE: bins_in_use_q <= cfg_data_i[BIU_W-1:0];
        default: ;
      endcase
    end
  end

  // active bin count: zero counts as one, anything above BINS counts as BINS
  assign biu_ext = CMPW'(bins_in_use_q);
  always_comb begin
    if (bins_in_use_q == '0) begin
      n_act = NW'(1);
    end else if (biu_ext > CMPW'(BINS)) begin
      n_act = NW'(BINS);
    end else begin
      n_act = NW'(bins_in_use_q);
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q        <= op_e'(op_i);
      series_q    <= series_i;
      sample_q    <= sample_i;
      bin_index_q <= bin_index_i;
      amount_q    <= amount_i;
      err_q       <= ({1'b0, series_i} >= (SERIES_W+1)'(SERIES));
    end
  end

  msh_binmap #(
    .BINS (BINS)
  ) u_binmap (
    .clk_i       (clk_i),
    .load_i      (state_q == S_MAP),
    .is_add_i    (op_q == OP_ADD),
    .sample_i    (sample_q),
    .range_min_i (range_min_q),
    .bin_scale_i (bin_scale_q),
    .bin_index_i (bin_index_q),
    .n_i         (n_act),
    .bin_o       (map_bin)
  );

  // series base address, only meaningful when the series is in range
  assign base     = XW'(series_q) * XW'(BINS);
  assign walk_idx = rd_cnt_q[BIW-1:0];
  assign issue    = (rd_cnt_q != n_act);

  always_comb begin
    if (state_q == S_ADDR) begin
      raddr = AW'(base + XW'(map_bin));
    end else begin
      raddr = AW'(base + XW'(walk_idx));
    end
  end

  // bin store writes: clearing pass, then add and set
  always_comb begin
    we    = 1'b0;
    waddr = AW'(base + XW'(bin_q));
    wdata = '0;
    if (state_q == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr_cnt_q;
    end else if (state_q == S_EXEC && !err_q) begin
      if (op_q == OP_ADD) begin
        we    = 1'b1;
        wdata = alu_sat40;
      end else if (op_q == OP_SET) begin
        we    = 1'b1;
        wdata = amount_q;
      end
    end
  end

  msh_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // adder operands: bin plus weight on add, running total plus next bin on sum
  always_comb begin
    if (state_q == S_EXEC) begin
      alu_a = ACCW'($signed(rdata));
      alu_b = $signed(amount_q);
    end else begin
      alu_a = acc_q;
      alu_b = rd_pend_q ? $signed(rdata) : '0;
    end
  end

  msh_alu #(
    .ACCW (ACCW)
  ) u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sum_o   (alu_sum),
    .sat40_o (alu_sat40),
    .sat48_o (alu_sat48)
  );

  // sequencer
  always_comb begin
    state_d   = state_q;
    bin_d     = bin_q;
    res_d     = res_q;
    acc_d     = acc_q;
    rd_cnt_d  = rd_cnt_q;
    rd_pend_d = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_cnt_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_MAP;
        end
      end
      S_MAP: begin
        state_d = S_ADDR;
      end
      S_ADDR: begin
        acc_d    = '0;
        rd_cnt_d = '0;
        if (op_q == OP_SUM) begin
          bin_d   = '0;
          res_d   = '0;
          state_d = err_q ? S_FIN : S_SUM;
        end else begin
          bin_d   = map_bin;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (op_q)
          OP_ADD:  res_d = OUT_W'(alu_sat40);
          OP_SET:  res_d = OUT_W'($signed(amount_q));
          OP_GET:  res_d = OUT_W'($signed(rdata));
          default: res_d = '0;
        endcase
        if (err_q) begin
          res_d = '0;
        end
        state_d = S_FIN;
      end
      S_SUM: begin
        // one read issued and one bin summed per cycle
        if (rd_pend_q) begin
          acc_d = alu_sum;
        end
        if (issue) begin
          rd_cnt_d  = rd_cnt_q + NW'(1);
          rd_pend_d = 1'b1;
        end else if (!rd_pend_q) begin
          res_d   = alu_sat48;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_cnt_q <= '0;
      rd_cnt_q  <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_cnt_q  <= rd_cnt_d;
      rd_pend_q <= rd_pend_d;
      if (state_q == S_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    res_q <= res_d;
    acc_q <= acc_d;
  end

  // result word, held while the downstream side stalls
  assign bin_used_ext = (BIW+BIN_USED_W)'(bin_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      value_q    <= res_q;
      bin_used_q <= bin_used_ext[BIN_USED_W-1:0];
      out_err_q  <= err_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign value_o        = value_q;
  assign bin_used_o     = bin_used_q;
  assign series_error_o = out_err_q;

endmodule
